// ----- design/rrc_pkg.sv -----
// ============================================================================
// rrc_pkg
// Shared widths, codes, types and helpers for the rotation composition block.
// ============================================================================
`default_nettype none

package rrc_pkg;

    // Exact products and sums of the composition fit in 100 bits, signed.
    localparam int W   = 100;
    localparam int MW  = 99;
    // Remainder width of the length division (root shifted into place).
    localparam int LW  = 132;
    // Sixteen-bit chunks covering the magnitude for the leading-one search.
    localparam int NCH = 7;

    localparam logic signed [W-1:0] ONE_Q62 = 100'sd1 <<< 62;

    localparam logic [1:0] REG_REF_X = 2'd0;
    localparam logic [1:0] REG_REF_Y = 2'd1;
    localparam logic [1:0] REG_REF_Z = 2'd2;

    typedef logic signed [W-1:0] wide_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       inf;
        logic       zero;
        logic       flip;
    } tag_t;

    typedef struct packed {
        logic [1:0]   user;
        logic [127:0] data;
    } out_t;

    function automatic logic [3:0] lead16(input logic [15:0] v);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/rodrigues_rotation_compose.sv -----
// ============================================================================
// rodrigues_rotation_compose
// Inverts an axis/tan-half rotation and composes it with a reference vector.
// ============================================================================
// The block accepts one item in every clock cycle while the output buffer is
// not full; a full buffer stalls the whole pipeline. The item passes through
// 79 register stages: 11 front stages, the square-root pipeline (a setup
// stage, then one root bit per stage over 32 stages), the division pipeline
// (a setup stage, then one quotient bit per stage over 33 stages) that forms
// the unit axis and the composed length, and the output buffer. The two-entry
// output buffer absorbs back-pressure, so s_axis_tready depends only on
// registered state. The reference vector is written through the cfg channel,
// which is always ready. Write it only while no item is in flight.
`default_nettype none

module rodrigues_rotation_compose (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // axis_x [31:0], axis_y [63:32], axis_z [95:64], tan_half [127:96]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_axis_x [31:0], res_axis_y [63:32], res_axis_z [95:64],
    // res_tan_half [127:96]
    output logic [127:0] m_axis_tdata,
    // is_infinite [0], overflow [1]
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NF = 11;
    localparam int NS = 32;
    localparam int ND = 33;

    logic en;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic signed [31:0] ref_reg [3];
    logic signed [31:0] ref_next [3];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ref_next[i] = ref_reg[i];
        end
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rrc_pkg::REG_REF_X: ref_next[0] = cfg_data;
                rrc_pkg::REG_REF_Y: ref_next[1] = cfg_data;
                rrc_pkg::REG_REF_Z: ref_next[2] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i] <= ref_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Front stages: products, sums, magnitudes, shift, squares
    // ------------------------------------------------------------------
    logic [NF:1] fv_reg;
    logic [NF:1] fv_next;

    logic signed [64:0]  rho1_reg [3], rho1_next [3];
    logic signed [64:0]  rho2_reg [3], rho2_next [3];
    logic signed [64:0]  ph2_reg [3][3], ph2_next [3][3];
    logic signed [64:0]  pl2_reg [3][3], pl2_next [3][3];
    logic signed [64:0]  rho3_reg [3], rho3_next [3];
    rrc_pkg::wide_t      p3_reg [3][3], p3_next [3][3];
    rrc_pkg::wide_t      a4_reg [3], a4_next [3];
    rrc_pkg::wide_t      c4_reg [3], c4_next [3];
    rrc_pkg::wide_t      dp4_reg, dp4_next, pz4_reg, pz4_next;
    rrc_pkg::wide_t      num5_reg [3], num5_next [3];
    rrc_pkg::wide_t      den5_reg, den5_next;
    logic [rrc_pkg::MW-1:0] m6_reg [3], m6_next [3];
    logic [rrc_pkg::MW-1:0] dab6_reg, dab6_next;
    rrc_pkg::tag_t          tag6_reg, tag6_next;
    logic [rrc_pkg::MW-1:0] m7_reg [3], dab7_reg;
    rrc_pkg::tag_t          tag7_reg;
    logic [rrc_pkg::NCH-1:0] nzc7_reg, nzc7_next;
    logic [3:0]             pos7_reg [rrc_pkg::NCH], pos7_next [rrc_pkg::NCH];
    logic [rrc_pkg::MW-1:0] m8_reg [3], dab8_reg;
    rrc_pkg::tag_t          tag8_reg;
    logic [6:0]             sh8_reg, sh8_next;
    logic [rrc_pkg::MW-1:0] m9_reg [3], m9_next [3], dab9_reg;
    rrc_pkg::tag_t          tag9_reg;
    logic [6:0]             sh9_reg;
    logic [30:0]            n10_reg [3], n10_next [3];
    logic [rrc_pkg::MW-1:0] dab10_reg;
    rrc_pkg::tag_t          tag10_reg;
    logic [6:0]             sh10_reg;
    logic [61:0]            sq11_reg [3], sq11_next [3];
    logic [30:0]            n11_reg [3];
    logic [rrc_pkg::MW-1:0] dab11_reg;
    rrc_pkg::tag_t          tag11_reg;
    logic [6:0]             sh11_reg;

    assign fv_next = {fv_reg[NF-1:1], s_axis_tvalid};

    always_comb
    begin
        logic signed [64:0] prod;
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        logic signed [64:0] ph;
        logic signed [64:0] pl;
        rrc_pkg::wide_t     phx;
        rrc_pkg::wide_t     plx;
        rrc_pkg::wide_t     rx;
        rrc_pkg::wide_t     sx;
        rrc_pkg::wide_t     v;
        integer             j;
        integer             k;
        logic               dneg;
        logic               nz;
        logic [111:0]       orv;
        logic [6:0]         bl;

        // Stage 1: rho = -(axis * tan_half).
        for (int i = 0; i < 3; i++)
        begin
            prod = 65'($signed(s_axis_tdata[32*i +: 32]))
                 * 65'($signed({1'b0, s_axis_tdata[127:96]}));
            rho1_next[i] = -prod;
        end

        // Stage 2: all nine reference-by-rho products as two partials each.
        for (int i = 0; i < 3; i++)
        begin
            rho2_next[i] = rho1_reg[i];
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                hi = rho1_reg[b][64:32];
                lo = $signed({1'b0, rho1_reg[b][31:0]});
                ph = 65'(ref_reg[a]) * 65'(hi);
                pl = 65'(ref_reg[a]) * 65'(lo);
                ph2_next[a][b] = ph;
                pl2_next[a][b] = pl;
            end
        end

        // Stage 3: recombine partials.
        for (int i = 0; i < 3; i++)
        begin
            rho3_next[i] = rho2_reg[i];
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                phx = rrc_pkg::wide_t'(ph2_reg[a][b]);
                plx = rrc_pkg::wide_t'(pl2_reg[a][b]);
                p3_next[a][b] = (phx <<< 32) + plx;
            end
        end

        // Stage 4: linear terms, cross product, partial dot product.
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            rx = rrc_pkg::wide_t'(rho3_reg[i]);
            sx = rrc_pkg::wide_t'(ref_reg[i]);
            a4_next[i] = (rx <<< 16) - (sx <<< 46);
            c4_next[i] = p3_reg[k][j] - p3_reg[j][k];
        end
        dp4_next = p3_reg[0][0] + p3_reg[1][1];
        pz4_next = p3_reg[2][2];

        // Stage 5: numerator and denominator.
        for (int i = 0; i < 3; i++)
        begin
            num5_next[i] = a4_reg[i] + c4_reg[i];
        end
        den5_next = rrc_pkg::ONE_Q62 + dp4_reg + pz4_reg;

        // Stage 6: case selection and magnitudes.
        tag6_next.inf = (den5_reg == '0);
        nz = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nz = nz | (num5_reg[i] != '0);
        end
        dneg = den5_reg[rrc_pkg::W-1];
        tag6_next.zero = !tag6_next.inf && !nz;
        // The regular case returns the negated axis unless the denominator is negative.
        tag6_next.flip = !tag6_next.inf && !dneg;
        for (int i = 0; i < 3; i++)
        begin
            sx = rrc_pkg::wide_t'(ref_reg[i]);
            v = tag6_next.inf ? sx : num5_reg[i];
            tag6_next.neg[i] = v[rrc_pkg::W-1];
            v = v[rrc_pkg::W-1] ? -v : v;
            m6_next[i] = v[rrc_pkg::MW-1:0];
        end
        v = dneg ? -den5_reg : den5_reg;
        dab6_next = v[rrc_pkg::MW-1:0];

        // Stage 7: per-chunk leading one of the OR of the magnitudes.
        orv = {13'b0, m6_reg[0] | m6_reg[1] | m6_reg[2]};
        for (int c = 0; c < rrc_pkg::NCH; c++)
        begin
            nzc7_next[c] = |orv[16*c +: 16];
            pos7_next[c] = rrc_pkg::lead16(orv[16*c +: 16]);
        end

        // Stage 8: bit length and right shift to 31 bits.
        bl = '0;
        for (int c = 0; c < rrc_pkg::NCH; c++)
        begin
            if (nzc7_reg[c])
            begin
                bl = 7'(16 * c) + 7'(pos7_reg[c]) + 7'd1;
            end
        end
        sh8_next = (bl > 7'd31) ? (bl - 7'd31) : 7'd0;

        // Stages 9 and 10: coarse then fine shift.
        for (int i = 0; i < 3; i++)
        begin
            m9_next[i] = m8_reg[i] >> {sh8_reg[6:4], 4'b0};
            n10_next[i] = 31'(m9_reg[i] >> sh9_reg[3:0]);
        end

        // Stage 11: squares.
        for (int i = 0; i < 3; i++)
        begin
            sq11_next[i] = 62'(n10_reg[i]) * 62'(n10_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rho1_reg[i]  <= rho1_next[i];
                rho2_reg[i]  <= rho2_next[i];
                rho3_reg[i]  <= rho3_next[i];
                a4_reg[i]    <= a4_next[i];
                c4_reg[i]    <= c4_next[i];
                num5_reg[i]  <= num5_next[i];
                m6_reg[i]    <= m6_next[i];
                m7_reg[i]    <= m6_reg[i];
                m8_reg[i]    <= m7_reg[i];
                m9_reg[i]    <= m9_next[i];
                n10_reg[i]   <= n10_next[i];
                sq11_reg[i]  <= sq11_next[i];
                n11_reg[i]   <= n10_reg[i];
                for (int b = 0; b < 3; b++)
                begin
                    ph2_reg[i][b] <= ph2_next[i][b];
                    pl2_reg[i][b] <= pl2_next[i][b];
                    p3_reg[i][b]  <= p3_next[i][b];
                end
            end
            dp4_reg  <= dp4_next;
            pz4_reg  <= pz4_next;
            den5_reg <= den5_next;
            tag6_reg <= tag6_next;
            dab6_reg <= dab6_next;
            tag7_reg <= tag6_reg;
            dab7_reg <= dab6_reg;
            nzc7_reg <= nzc7_next;
            for (int c = 0; c < rrc_pkg::NCH; c++)
            begin
                pos7_reg[c] <= pos7_next[c];
            end
            tag8_reg  <= tag7_reg;
            dab8_reg  <= dab7_reg;
            sh8_reg   <= sh8_next;
            tag9_reg  <= tag8_reg;
            dab9_reg  <= dab8_reg;
            sh9_reg   <= sh8_reg;
            tag10_reg <= tag9_reg;
            dab10_reg <= dab9_reg;
            sh10_reg  <= sh9_reg;
            tag11_reg <= tag10_reg;
            dab11_reg <= dab10_reg;
            sh11_reg  <= sh10_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage
    // ------------------------------------------------------------------
    logic                   sv_reg [NS+1];
    logic [63:0]            srem_reg [NS+1];
    logic [31:0]            sroot_reg [NS+1];
    logic [30:0]            sn_reg [NS+1][3];
    rrc_pkg::tag_t          stag_reg [NS+1];
    logic [rrc_pkg::MW-1:0] sdab_reg [NS+1];
    logic [6:0]             ssh_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= fv_reg[NF];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0]  <= 64'(sq11_reg[0]) + 64'(sq11_reg[1]) + 64'(sq11_reg[2]);
            sroot_reg[0] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sn_reg[0][i] <= n11_reg[i];
            end
            stag_reg[0] <= tag11_reg;
            sdab_reg[0] <= dab11_reg;
            ssh_reg[0]  <= sh11_reg;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        localparam int I = NS - 1 - k;
        logic [63:0] rem_next;
        logic [31:0] root_next;

        always_comb
        begin
            logic [65:0] trial;
            trial = (66'(sroot_reg[k]) << (I + 1)) + (66'd1 << (2 * I));
            rem_next  = srem_reg[k];
            root_next = sroot_reg[k];
            if ({2'b0, srem_reg[k]} >= trial)
            begin
                rem_next  = srem_reg[k] - 64'(trial);
                root_next = sroot_reg[k] | (32'd1 << I);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[k+1]  <= rem_next;
                sroot_reg[k+1] <= root_next;
                for (int i = 0; i < 3; i++)
                begin
                    sn_reg[k+1][i] <= sn_reg[k][i];
                end
                stag_reg[k+1] <= stag_reg[k];
                sdab_reg[k+1] <= sdab_reg[k];
                ssh_reg[k+1]  <= ssh_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Division: axis components by the root, length by the denominator
    // ------------------------------------------------------------------
    logic                   dv_reg [ND+1];
    logic [61:0]            arem_reg [ND+1][3];
    logic [30:0]            aq_reg [ND+1][3];
    logic [rrc_pkg::LW-1:0] lrem_reg [ND+1];
    logic [32:0]            lq_reg [ND+1];
    logic [31:0]            dr_reg [ND+1];
    rrc_pkg::tag_t          dtag_reg [ND+1];
    logic [rrc_pkg::MW-1:0] ddab_reg [ND+1];
    logic [31:0]            droot;

    // A zero root is used as one.
    assign droot = (sroot_reg[NS] == '0) ? 32'd1 : sroot_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= sv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // Round half up: add half the divisor before dividing.
                arem_reg[0][i] <= {1'b0, sn_reg[NS][i], 30'b0} + 62'(droot >> 1);
                aq_reg[0][i]   <= '0;
            end
            lrem_reg[0] <= rrc_pkg::LW'(droot) << (8'(ssh_reg[NS]) + 8'd16);
            lq_reg[0]   <= '0;
            dr_reg[0]   <= droot;
            dtag_reg[0] <= stag_reg[NS];
            ddab_reg[0] <= sdab_reg[NS];
        end
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        localparam int B = ND - 1 - k;
        logic [61:0]            arem_next [3];
        logic [30:0]            aq_next [3];
        logic [rrc_pkg::LW-1:0] lrem_next;
        logic [32:0]            lq_next;

        always_comb
        begin
            logic [rrc_pkg::LW-1:0] ltrial;
            logic [61:0]            atrial;
            atrial    = '0;
            ltrial    = rrc_pkg::LW'(ddab_reg[k]) << B;
            lrem_next = lrem_reg[k];
            lq_next   = lq_reg[k];
            if (lrem_reg[k] >= ltrial)
            begin
                lrem_next = lrem_reg[k] - ltrial;
                lq_next   = lq_reg[k] | (33'd1 << B);
            end
            for (int i = 0; i < 3; i++)
            begin
                arem_next[i] = arem_reg[k][i];
                aq_next[i]   = aq_reg[k][i];
            end
            // The unit quotient never exceeds 2^30, so higher bits are skipped.
            if (B <= 30)
            begin
                atrial = 62'(dr_reg[k]) << B;
                for (int i = 0; i < 3; i++)
                begin
                    if (arem_reg[k][i] >= atrial)
                    begin
                        arem_next[i] = arem_reg[k][i] - atrial;
                        aq_next[i]   = aq_reg[k][i] | 31'(64'd1 << B);
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    arem_reg[k+1][i] <= arem_next[i];
                    aq_reg[k+1][i]   <= aq_next[i];
                end
                lrem_reg[k+1] <= lrem_next;
                lq_reg[k+1]   <= lq_next;
                dr_reg[k+1]   <= dr_reg[k];
                dtag_reg[k+1] <= dtag_reg[k];
                ddab_reg[k+1] <= ddab_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly and two-entry output buffer
    // ------------------------------------------------------------------
    rrc_pkg::out_t res;
    rrc_pkg::out_t bf_reg [2];
    rrc_pkg::out_t bf_next [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    always_comb
    begin
        logic [31:0]   q;
        logic [31:0]   tan;
        logic          ovf;
        rrc_pkg::tag_t tg;
        tg = dtag_reg[ND];
        for (int i = 0; i < 3; i++)
        begin
            q = {1'b0, aq_reg[ND][i]};
            if (tg.zero)
            begin
                res.data[32*i +: 32] = '0;
            end
            else
            begin
                res.data[32*i +: 32] = (tg.neg[i] ^ tg.flip) ? -q : q;
            end
        end
        ovf = !tg.inf && !tg.zero && lq_reg[ND][32];
        if (tg.inf || ovf)
        begin
            tan = '1;
        end
        else if (tg.zero)
        begin
            tan = '0;
        end
        else
        begin
            tan = lq_reg[ND][31:0];
        end
        res.data[127:96] = tan;
        res.user = {ovf, tg.inf};
    end

    assign en   = (cnt_reg != 2'd2);
    assign push = en && dv_reg[ND];
    assign pop  = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = en;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = bf_reg[0].data;
    assign m_axis_tuser  = bf_reg[0].user;

    always_comb
    begin
        cnt_next   = cnt_reg + 2'(push) - 2'(pop);
        bf_next[0] = bf_reg[0];
        bf_next[1] = bf_reg[1];
        if (pop)
        begin
            bf_next[0] = bf_reg[1];
        end
        if (push)
        begin
            if ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop))
            begin
                bf_next[0] = res;
            end
            else
            begin
                bf_next[1] = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bf_reg[0] <= bf_next[0];
        bf_reg[1] <= bf_next[1];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_inf_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("infinite item also flagged as overflow");

    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]))
            |-> (m_axis_tdata[127:96] == 32'hFFFF_FFFF))
        else $error("saturated item without all-ones length");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && dv_reg[ND]) |=> dv_reg[ND])
        else $error("last stage item dropped while buffer full");

endmodule

`default_nettype wire

// ----- dv/tb_rodrigues_rotation_compose.sv -----
// ============================================================================
// tb_rodrigues_rotation_compose
// Self-checking bench: directed and random rotations against an exact-integer
// predictor of the inversion, composition and normalization, with random
// stalls on both stream sides and several reference-vector settings.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_rodrigues_rotation_compose;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] th;
        logic        inf;
        logic        ovf;
    } result_t;

    typedef struct {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] th;
        logic        chk;
        logic [31:0] ex_ax;
        logic [31:0] ex_ay;
        logic [31:0] ex_az;
        logic [31:0] ex_th;
        logic        ex_inf;
        logic        ex_ovf;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    logic signed [31:0] sigma [3];
    result_t expected_q [$];
    int  mismatches;
    bit  quiet;
    bit  failed;
    longint unsigned recv_count;

    rodrigues_rotation_compose uut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [127:0] mag128(input logic signed [127:0] v);
        return v[127] ? -v : v;
    endfunction

    function automatic int bit_length(input logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Normalize a nonzero vector to Q2.30, returning the root and shift used.
    task automatic unit_vector(input logic signed [127:0] v [3],
                               output logic [31:0] o [3],
                               output logic [63:0] root, output int shift);
        logic [127:0] m [3];
        logic [63:0]  n [3];
        logic [63:0]  sum;
        logic [63:0]  r;
        logic [63:0]  q;
        int bl;
        bl = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag128(v[i]);
            if (bit_length(m[i]) > bl)
            begin
                bl = bit_length(m[i]);
            end
        end
        shift = bl > 31 ? bl - 31 : 0;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = 64'(m[i] >> shift);
            sum += n[i] * n[i];
        end
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= sum)
            begin
                r |= 64'd1 << b;
            end
        end
        if (r == 0)
        begin
            r = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = ((n[i] << 30) + (r >> 1)) / r;
            o[i] = v[i][127] ? 32'(-q) : 32'(q);
        end
        root = r;
    endtask

    task automatic compose_rotation(input logic [31:0] ax, input logic [31:0] ay,
                                    input logic [31:0] az, input logic [31:0] th,
                                    output result_t res);
        logic signed [127:0] rho [3];
        logic signed [127:0] sg [3];
        logic signed [127:0] num [3];
        logic signed [127:0] den;
        logic [31:0] a_in [3];
        logic [31:0] o [3];
        logic [63:0] root;
        logic [127:0] nn;
        logic [127:0] dd;
        int s;
        int j;
        int k;
        a_in[0] = ax;
        a_in[1] = ay;
        a_in[2] = az;
        den = 128'sd1 <<< 62;
        for (int i = 0; i < 3; i++)
        begin
            sg[i] = 128'(sigma[i]);
            rho[i] = -(128'($signed(a_in[i])) * $signed({96'd0, th}));
            den += sg[i] * rho[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            num[i] = (rho[i] <<< 16) - (sg[i] <<< 46) + rho[j] * sg[k] - rho[k] * sg[j];
        end
        res = '0;
        if (den == 0)
        begin
            unit_vector(sg, o, root, s);
            res.ax = o[0];
            res.ay = o[1];
            res.az = o[2];
            res.th = 32'hFFFF_FFFF;
            res.inf = 1'b1;
        end
        else if (num[0] != 0 || num[1] != 0 || num[2] != 0)
        begin
            unit_vector(num, o, root, s);
            res.ax = den[127] ? o[0] : -o[0];
            res.ay = den[127] ? o[1] : -o[1];
            res.az = den[127] ? o[2] : -o[2];
            nn = 128'(root) << (s + 16);
            dd = mag128(den);
            // Compare before dividing; the shifted root can exceed 128 bits only
            // when the quotient saturates anyway.
            if (s + 16 + bit_length(128'(root)) > 128
                || {32'd0, nn} >= ({32'd0, dd} << 32))
            begin
                res.th = 32'hFFFF_FFFF;
                res.ovf = 1'b1;
            end
            else
            begin
                res.th = 32'(nn / dd);
            end
        end
    endtask

    // The caller drops cfg_valid after its last write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        case (idx)
            rrc_pkg::REG_REF_X: sigma[0] = val;
            rrc_pkg::REG_REF_Y: sigma[1] = val;
            rrc_pkg::REG_REF_Z: sigma[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_sigma(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        write_reg(rrc_pkg::REG_REF_X, x);
        write_reg(rrc_pkg::REG_REF_Y, y);
        write_reg(rrc_pkg::REG_REF_Z, z);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
    endtask

    task automatic send_rotation(input logic [31:0] ax, input logic [31:0] ay,
                                 input logic [31:0] az, input logic [31:0] th,
                                 input bit typed, input result_t typed_res);
        result_t res;
        if (!quiet && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        s_axis_tdata  <= {th, az, ay, ax};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (typed)
        begin
            res = typed_res;
        end
        else
        begin
            compose_rotation(ax, ay, az, th, res);
        end
        expected_q.insert(expected_q.size(), res);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_axis_comp();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 ** 30)) * ($urandom_range(1) ? 1 : -1));
            2: return 32'($signed($urandom_range(2047)) - 1024);
            default: return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000);
            2: return $urandom_range(255);
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    // Sink side: random stalls, compares every item against the oldest expectation.
    always @(negedge clk)
    begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            recv_count++;
            if (expected_q.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected item: %h user %b", m_axis_tdata, m_axis_tuser);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata != {want.th, want.az, want.ay, want.ax}
                    || m_axis_tuser != {want.ovf, want.inf})
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch axis %h %h %h tan %h inf %b ovf %b",
                                 m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[95:64], m_axis_tdata[127:96],
                                 m_axis_tuser[0], m_axis_tuser[1]);
                        $display("   expected %h %h %h tan %h inf %b ovf %b",
                                 want.ax, want.ay, want.az, want.th, want.inf, want.ovf);
                    end
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    localparam logic [31:0] ONE_A  = 32'h4000_0000;
    localparam logic [31:0] MONE_A = 32'hC000_0000;
    localparam logic [31:0] ONE_T  = 32'h0001_0000;

    row_t dir_rows [$];

    task automatic add_row(input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] az, input logic [31:0] th);
        row_t r;
        r = '{ax, ay, az, th, 1'b0, 0, 0, 0, 0, 1'b0, 1'b0};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial
    begin
        result_t tr;
        int sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rrc_pkg::REG_REF_X;
        cfg_data = '0;
        quiet = 1'b0;
        failed = 1'b0;
        mismatches = 0;
        recv_count = 0;
        sigma[0] = 0;
        sigma[1] = 0;
        sigma[2] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed table; rows with typed results use the reset reference of zero,
        // where the result is just the negated inversion: axis unchanged, same length.
        dir_rows.insert(dir_rows.size(),
                        row_t'{ONE_A, 0, 0, ONE_T, 1'b1, ONE_A, 0, 0, ONE_T, 1'b0, 1'b0});
        dir_rows.insert(dir_rows.size(),
                        row_t'{0, MONE_A, 0, 32'h0002_0000, 1'b1,
                               0, MONE_A, 0, 32'h0002_0000, 1'b0, 1'b0});
        // A zero length or a zero axis gives a zero numerator and so all zeros.
        dir_rows.insert(dir_rows.size(),
                        row_t'{ONE_A, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1'b0, 1'b0});
        dir_rows.insert(dir_rows.size(),
                        row_t'{0, 0, 0, 32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0, 1'b0, 1'b0});
        // Largest length on a unit axis fits, but the 31-bit normalization
        // drops the lowest bit of the length.
        dir_rows.insert(dir_rows.size(),
                        row_t'{0, 0, ONE_A, 32'hFFFF_FFFF, 1'b1,
                               0, 0, ONE_A, 32'hFFFF_FFFE, 1'b0, 1'b0});
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
        add_row(32'h0000_0001, 0, 0, 32'h0000_0001);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        foreach (dir_rows[i])
        begin
            tr = '{dir_rows[i].ex_ax, dir_rows[i].ex_ay, dir_rows[i].ex_az,
                   dir_rows[i].ex_th, dir_rows[i].ex_inf, dir_rows[i].ex_ovf};
            send_rotation(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az,
                          dir_rows[i].th, dir_rows[i].chk, tr);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Reference of unit tan along x: a matching rotation hits a zero denominator,
        // the exact inverse of it cancels the numerator.
        set_sigma(32'h0001_0000, 0, 0);
        send_rotation(MONE_A, 0, 0, ONE_T, 1'b0, tr);
        send_rotation(ONE_A, 0, 0, ONE_T, 1'b0, tr);
        send_rotation(0, ONE_A, 0, ONE_T, 1'b0, tr);
        send_rotation(MONE_A, 0, 0, 32'h0000_FFFF, 1'b0, tr);
        send_rotation(MONE_A, 0, 0, 32'h0001_0001, 1'b0, tr);
        send_rotation(0, 0, ONE_A, 32'hFFFF_FFFF, 1'b0, tr);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        set_sigma(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_rotation(ONE_A, ONE_A, 0, 32'hFFFF_FFFF, 1'b0, tr);
        send_rotation(0, 0, 0, 32'h1234_5678, 1'b0, tr);
        send_rotation(32'h2000_0000, 0, 0, 32'h0000_0002, 1'b0, tr);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random part in phases, each with a fresh reference setting.
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_sigma(0, 0, 0);
                1: set_sigma(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                2: set_sigma(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                default: set_sigma(rand_q16() ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0),
                                   rand_q16() ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0),
                                   rand_q16() ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0));
            endcase
            quiet = (ph == 5);
            for (int n = 0; n < 155; n++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // Line the rotation up as the exact inverse of the reference's x part to
                    // provoke the cancelling case.
                    send_rotation(sigma[0][31] ? ONE_A : MONE_A, 0, 0,
                                  32'(sigma[0][31] ? -sigma[0] : sigma[0]), 1'b0, tr);
                end
                else
                begin
                    send_rotation(rand_axis_comp(), rand_axis_comp(), rand_axis_comp(),
                                  rand_q16(), 1'b0, tr);
                end
                sent++;
            end
            s_axis_tvalid <= 1'b0;
            quiet = 1'b0;
            wait_drained();
        end

        if (!failed && expected_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
